// File: hdl/assert_macros.svh
// assertion helpers included by the allocator rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every rising clock edge outside reset
`define ASSERT_CHK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("pcta assertion failed");

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("pcta forbidden condition seen");

`else

`define ASSERT_CHK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)

`endif

`endif

// File: hdl/pcta_pkg.sv
package pcta_pkg;

    // parameter defaults
    localparam int MAX_ENTRIES_DEF = 16;
    localparam int PAGE_BITS_DEF   = 24;

    // field widths
    localparam int CNT_W   = 5;   // entry_count register
    localparam int MAXP_W  = 21;  // per-entry page count
    localparam int PAGES_W = 25;  // page totals and requests
    localparam int OP_W    = 26;  // shared unit operand width
    localparam int IDX_W   = 4;   // entry index port
    localparam int ADDR_W  = 4;   // apb address
    localparam int DATA_W  = 32;  // apb data

    // register map (word index)
    localparam logic [1:0] REG_ENTRY_COUNT = 2'd0;
    localparam logic [1:0] REG_MAX_PAGES   = 2'd1;
    localparam logic [1:0] REG_TOTAL_PAGES = 2'd2;

    // register reset values
    localparam logic [CNT_W-1:0]   DEF_ENTRY_COUNT = 5'd16;
    localparam logic [MAXP_W-1:0]  DEF_MAX_PAGES   = 21'd4096;
    localparam logic [PAGES_W-1:0] DEF_TOTAL_PAGES = 25'd65536;

    // per-entry maximum ceiling
    localparam logic [MAXP_W-1:0] PER_MAX = 21'h100000;

    // commands
    localparam logic CMD_ALLOC   = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    // result status codes
    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_NOFREE = 2'd1;
    localparam logic [1:0] STAT_BADREL = 2'd2;

    // effective configuration handed to the sequencer
    typedef struct packed {
        logic [CNT_W-1:0]   count;      // clamped entry count
        logic [MAXP_W-1:0]  max_pages;  // clamped per-entry maximum
        logic [PAGES_W-1:0] total;      // raw total register
        logic               reload;     // a register was written
    } t_cfg;

endpackage

// File: hdl/page_count_table_allocator.sv
// a release runs the index check, total check, entry add and per-entry max check, one result;
//   an allocate answers zero or over-limit requests from its first check, else scans first-fit
//   and then spills over the entries, one add/subtract per cycle in the shared unit
// one request at a time; the next start is taken once busy drops
// reset and any register write reload the table (cap, total clamp, entry fill), busy high
// results are one-cycle strobes; the receiver cannot stall them
module page_count_table_allocator
    import pcta_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
    parameter int PAGE_BITS   = PAGE_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // request side
    input  logic               start,
    output logic               busy,
    input  logic               i_cmd,
    input  logic [PAGES_W-1:0] i_request_pages,
    input  logic [IDX_W-1:0]   i_release_entry,
    // result side
    output logic               o_result_valid,
    output logic [1:0]         o_status,
    output logic [IDX_W-1:0]   o_entry_index,
    output logic [PAGES_W-1:0] o_granted_pages,
    output logic [PAGES_W-1:0] o_free_after,
    output logic               o_last,
    // configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [DATA_W-1:0]  pwdata,
    output logic [DATA_W-1:0]  prdata,
    output logic               pready
);

`include "assert_macros.svh"

    // table depth follows the entry limit
    localparam int ENT_LIMIT = (MAX_ENTRIES < 16) ? MAX_ENTRIES : 16;
    localparam int IdxW      = (ENT_LIMIT > 1) ? $clog2(ENT_LIMIT) : 1;
    localparam logic [IDX_W-1:0] LastIdx = IDX_W'(ENT_LIMIT - 1);

    // total page ceiling from the page address width
    localparam logic [40:0] PageLim = 41'(1) << PAGE_BITS;

    // sequencer states
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_LD_CAP  = 4'd1;   // cap = max * count
    localparam logic [3:0] S_LD_TOT  = 4'd2;   // clamp total
    localparam logic [3:0] S_LD_ENT  = 4'd3;   // fill one entry per cycle
    localparam logic [3:0] S_RL_CHK  = 4'd4;   // index check, free + req
    localparam logic [3:0] S_RL_TOT  = 4'd5;   // compare against total
    localparam logic [3:0] S_RL_ENT  = 4'd6;   // entry + req
    localparam logic [3:0] S_RL_MAX  = 4'd7;   // compare against per-entry max
    localparam logic [3:0] S_AL_CHK  = 4'd8;   // zero / enough free check
    localparam logic [3:0] S_AL_FIT  = 4'd9;   // first-fit scan
    localparam logic [3:0] S_AL_SPL  = 4'd10;  // spill scan
    localparam logic [3:0] S_AL_PART = 4'd11;  // partial take from last entry

    t_cfg cfg;

    // sequencer registers
    logic [3:0]         r_state,     n_state;
    logic [IDX_W-1:0]   r_idx,       n_idx;
    logic [PAGES_W-1:0] r_req,       n_req;
    logic [PAGES_W-1:0] r_free,      n_free;
    logic [PAGES_W-1:0] r_eff_total, n_eff_total;
    logic [OP_W-1:0]    r_cap,       n_cap;
    logic [OP_W-1:0]    r_tmp,       n_tmp;    // free after, or free + req
    logic [OP_W-1:0]    r_acc,       n_acc;    // remaining pages, or entry + req

    // page count table
    logic [MAXP_W-1:0] r_table [ENT_LIMIT];
    logic [MAXP_W-1:0] r_tbl_rd;
    logic [MAXP_W-1:0] tbl_rd;
    logic              tbl_we;
    logic [MAXP_W-1:0] tbl_wd;

    // result registers
    logic               r_out_valid;
    logic [1:0]         r_status,  n_status;
    logic [IDX_W-1:0]   r_index,   n_index;
    logic [PAGES_W-1:0] r_granted, n_granted;
    logic [PAGES_W-1:0] r_fafter,  n_fafter;
    logic               r_last,    n_last;
    logic               emit;

    // shared add/subtract unit
    logic [OP_W-1:0] alu_a, alu_b, alu_res;
    logic            alu_sub, alu_carry;

    logic [OP_W-1:0]    rd26, max26, req26, free26;
    logic [OP_W-1:0]    tot_min;
    logic [PAGES_W-1:0] tot_clamp;
    logic               idx_in, idx_last;

    pcta_regs #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    pcta_alu u_alu (
        .i_a     (alu_a),
        .i_b     (alu_b),
        .i_sub   (alu_sub),
        .o_res   (alu_res),
        .o_carry (alu_carry)
    );

    // registered read port; addressed with the next index so the data lines up
    // with r_idx (a write targets the entry read in the next cycle only when returning to idle)
    assign tbl_rd = r_tbl_rd;

    assign rd26     = {{(OP_W-MAXP_W){1'b0}}, tbl_rd};
    assign max26    = {{(OP_W-MAXP_W){1'b0}}, cfg.max_pages};
    assign req26    = {1'b0, r_req};
    assign free26   = {1'b0, r_free};
    assign idx_in   = {1'b0, r_idx} < cfg.count;
    assign idx_last = {1'b0, r_idx} == (cfg.count - CNT_W'(1));

    // min(total, cap) comes from the unit; the page-width ceiling is a constant compare
    assign tot_min   = alu_carry ? {1'b0, cfg.total} : r_cap;
    assign tot_clamp = ({15'd0, tot_min} > PageLim) ? PAGES_W'(PageLim)
                                                    : tot_min[PAGES_W-1:0];

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_req       = r_req;
        n_free      = r_free;
        n_eff_total = r_eff_total;
        n_cap       = r_cap;
        n_tmp       = r_tmp;
        n_acc       = r_acc;
        tbl_we      = 1'b0;
        tbl_wd      = '0;
        emit        = 1'b0;
        n_status    = STAT_OK;
        n_index     = r_idx;
        n_granted   = '0;
        n_fafter    = r_free;
        n_last      = 1'b1;
        alu_a       = '0;
        alu_b       = '0;
        alu_sub     = 1'b1;

        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_req = i_request_pages;
                    if (i_cmd == CMD_ALLOC) begin
                        n_idx   = '0;
                        n_state = S_AL_CHK;
                    end else begin
                        n_idx   = i_release_entry;
                        n_state = S_RL_CHK;
                    end
                end
            end

            // ---- table load ----
            S_LD_CAP: begin
                n_cap   = OP_W'({5'd0, cfg.max_pages} * {21'd0, cfg.count});
                n_state = S_LD_TOT;
            end
            S_LD_TOT: begin
                alu_a       = {1'b0, cfg.total};
                alu_b       = r_cap;
                n_eff_total = tot_clamp;
                n_free      = tot_clamp;
                n_acc       = {1'b0, tot_clamp};
                n_idx       = '0;
                n_state     = S_LD_ENT;
            end
            S_LD_ENT: begin
                alu_a  = r_acc;
                alu_b  = max26;
                tbl_we = 1'b1;
                if (idx_in) begin
                    if (alu_carry) begin
                        // remainder below the maximum goes whole into this entry
                        tbl_wd = r_acc[MAXP_W-1:0];
                        n_acc  = '0;
                    end else begin
                        tbl_wd = cfg.max_pages;
                        n_acc  = alu_res;
                    end
                end
                if (r_idx == LastIdx) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end

            // ---- release ----
            S_RL_CHK: begin
                alu_sub = 1'b0;
                alu_a   = free26;
                alu_b   = req26;
                if (!idx_in) begin
                    emit     = 1'b1;
                    n_status = STAT_BADREL;
                    n_state  = S_IDLE;
                end else begin
                    n_tmp   = alu_res;
                    n_state = S_RL_TOT;
                end
            end
            S_RL_TOT: begin
                alu_a = {1'b0, r_eff_total};
                alu_b = r_tmp;
                if (alu_carry) begin
                    emit     = 1'b1;
                    n_status = STAT_BADREL;
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_RL_ENT;
                end
            end
            S_RL_ENT: begin
                alu_sub = 1'b0;
                alu_a   = rd26;
                alu_b   = req26;
                n_acc   = alu_res;
                n_state = S_RL_MAX;
            end
            S_RL_MAX: begin
                alu_a   = max26;
                alu_b   = r_acc;
                emit    = 1'b1;
                n_state = S_IDLE;
                if (alu_carry) begin
                    n_status = STAT_BADREL;
                end else begin
                    tbl_we    = 1'b1;
                    tbl_wd    = r_acc[MAXP_W-1:0];
                    n_free    = r_tmp[PAGES_W-1:0];
                    n_granted = r_req;
                    n_fafter  = r_tmp[PAGES_W-1:0];
                end
            end

            // ---- allocate ----
            S_AL_CHK: begin
                alu_a   = free26;
                alu_b   = req26;
                n_index = '0;
                if (r_req == '0) begin
                    emit    = 1'b1;
                    n_state = S_IDLE;
                end else if (alu_carry) begin
                    emit     = 1'b1;
                    n_status = STAT_NOFREE;
                    n_state  = S_IDLE;
                end else begin
                    n_tmp   = alu_res;
                    n_idx   = '0;
                    n_state = S_AL_FIT;
                end
            end
            S_AL_FIT: begin
                alu_a = rd26;
                alu_b = req26;
                if (!alu_carry) begin
                    // whole request fits in this entry
                    tbl_we    = 1'b1;
                    tbl_wd    = alu_res[MAXP_W-1:0];
                    n_free    = r_tmp[PAGES_W-1:0];
                    emit      = 1'b1;
                    n_granted = r_req;
                    n_fafter  = r_tmp[PAGES_W-1:0];
                    n_state   = S_IDLE;
                end else if (idx_last) begin
                    n_free  = r_tmp[PAGES_W-1:0];
                    n_acc   = req26;
                    n_idx   = '0;
                    n_state = S_AL_SPL;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            S_AL_SPL: begin
                alu_a = r_acc;
                alu_b = rd26;
                if (tbl_rd == '0) begin
                    if (idx_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end else if (!alu_carry) begin
                    // drain this entry completely
                    tbl_we    = 1'b1;
                    tbl_wd    = '0;
                    n_acc     = alu_res;
                    emit      = 1'b1;
                    n_granted = {{(PAGES_W-MAXP_W){1'b0}}, tbl_rd};
                    n_last    = (alu_res == '0) || idx_last;
                    if (n_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end else begin
                    n_state = S_AL_PART;
                end
            end
            S_AL_PART: begin
                alu_a     = rd26;
                alu_b     = r_acc;
                tbl_we    = 1'b1;
                tbl_wd    = alu_res[MAXP_W-1:0];
                emit      = 1'b1;
                n_granted = r_acc[PAGES_W-1:0];
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // a register write restarts the table load
        if (cfg.reload) begin
            n_state = S_LD_CAP;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LD_CAP;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_free      <= n_free;
        r_eff_total <= n_eff_total;
        r_cap       <= n_cap;
        r_tmp       <= n_tmp;
        r_acc       <= n_acc;
        if (emit) begin
            r_status  <= n_status;
            r_index   <= n_index;
            r_granted <= n_granted;
            r_fafter  <= n_fafter;
            r_last    <= n_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_table[r_idx[IdxW-1:0]] <= tbl_wd;
        end
        r_tbl_rd <= r_table[n_idx[IdxW-1:0]];
    end

    assign busy            = (r_state != S_IDLE);
    assign o_result_valid  = r_out_valid;
    assign o_status        = r_status;
    assign o_entry_index   = r_index;
    assign o_granted_pages = r_granted;
    assign o_free_after    = r_fafter;
    assign o_last          = r_last;

    // results only come out of a request in progress
    `ASSERT_CHK(a_result_from_work, i_clk, i_rst_n, o_result_valid |-> $past(r_state) != S_IDLE)
    // the final result of a request is never followed at once by another
    `ASSERT_CHK(a_last_then_gap, i_clk, i_rst_n, (o_result_valid && o_last) |=> !o_result_valid)
    // error results always close their request
    `ASSERT_CHK(a_error_is_last, i_clk, i_rst_n, (o_result_valid && o_status != STAT_OK) |-> o_last)
    // free total never runs past the clamped total between requests
    `ASSERT_NEVER(a_free_bound, i_clk, i_rst_n, (r_state == S_IDLE) && (r_free > r_eff_total))
    // spill scan only runs while pages remain to be placed
    `ASSERT_NEVER(a_spill_remain, i_clk, i_rst_n, (r_state == S_AL_SPL) && (r_acc == '0))

endmodule

// File: hdl/pcta_alu.sv
module pcta_alu
    import pcta_pkg::*;
(
    input  logic [OP_W-1:0] i_a,
    input  logic [OP_W-1:0] i_b,
    input  logic            i_sub,
    output logic [OP_W-1:0] o_res,
    output logic            o_carry
);

    logic [OP_W:0] full;

    // carry out on add, borrow (a < b) on subtract
    always_comb begin
        if (i_sub) begin
            full = {1'b0, i_a} - {1'b0, i_b};
        end else begin
            full = {1'b0, i_a} + {1'b0, i_b};
        end
    end

    assign o_res   = full[OP_W-1:0];
    assign o_carry = full[OP_W];

endmodule

// File: hdl/pcta_regs.sv
module pcta_regs
    import pcta_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    localparam int ENT_LIMIT = (MAX_ENTRIES < 16) ? MAX_ENTRIES : 16;
    localparam logic [CNT_W-1:0] EntLimit = CNT_W'(ENT_LIMIT);

    logic [CNT_W-1:0]   r_entry_count;
    logic [MAXP_W-1:0]  r_max_pages;
    logic [PAGES_W-1:0] r_total_pages;

    logic [1:0] reg_idx;
    logic       wr_fire;
    logic       reg_hit;

    assign reg_idx = paddr[3:2];
    assign wr_fire = psel & penable & pwrite;
    assign reg_hit = (reg_idx == REG_ENTRY_COUNT) || (reg_idx == REG_MAX_PAGES) ||
                     (reg_idx == REG_TOTAL_PAGES);
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= DEF_ENTRY_COUNT;
            r_max_pages   <= DEF_MAX_PAGES;
            r_total_pages <= DEF_TOTAL_PAGES;
        end else if (wr_fire) begin
            unique case (reg_idx)
                REG_ENTRY_COUNT: r_entry_count <= pwdata[CNT_W-1:0];
                REG_MAX_PAGES:   r_max_pages   <= pwdata[MAXP_W-1:0];
                REG_TOTAL_PAGES: r_total_pages <= pwdata[PAGES_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_ENTRY_COUNT: prdata = DATA_W'(r_entry_count);
            REG_MAX_PAGES:   prdata = DATA_W'(r_max_pages);
            REG_TOTAL_PAGES: prdata = DATA_W'(r_total_pages);
            default:         prdata = '0;
        endcase
    end

    // clamp count and per-entry maximum into their legal ranges
    always_comb begin
        priority if (r_entry_count == '0) begin
            o_cfg.count = CNT_W'(1);
        end else if (r_entry_count > EntLimit) begin
            o_cfg.count = EntLimit;
        end else begin
            o_cfg.count = r_entry_count;
        end

        priority if (r_max_pages == '0) begin
            o_cfg.max_pages = MAXP_W'(1);
        end else if (r_max_pages > PER_MAX) begin
            o_cfg.max_pages = PER_MAX;
        end else begin
            o_cfg.max_pages = r_max_pages;
        end

        o_cfg.total  = r_total_pages;
        o_cfg.reload = wr_fire & reg_hit;
    end

endmodule

// File: tb/testbench.sv
module testbench;
    import pcta_pkg::*;

    // predictor works at the default build of the block
    localparam int SLOT_LIMIT = (MAX_ENTRIES_DEF < 16) ? MAX_ENTRIES_DEF : 16;
    localparam longint unsigned PAGE_CEIL = 64'd1 << PAGE_BITS_DEF;

    // one result of a request
    typedef struct packed {
        logic [1:0]         status;
        logic [IDX_W-1:0]   slot;
        logic [PAGES_W-1:0] granted;
        logic [PAGES_W-1:0] free_after;
        logic               last;
    } t_grant;

    // one line of the directed plan: a register write or a request
    typedef struct {
        bit                 is_write;
        logic [1:0]         reg_idx;
        logic [DATA_W-1:0]  reg_value;
        logic               cmd;
        logic [PAGES_W-1:0] pages;
        logic [IDX_W-1:0]   slot;
        bit                 typed;
        t_grant             want;
    } t_plan_row;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic               i_cmd = CMD_ALLOC;
    logic [PAGES_W-1:0] i_request_pages = '0;
    logic [IDX_W-1:0]   i_release_entry = '0;
    logic               o_result_valid;
    logic [1:0]         o_status;
    logic [IDX_W-1:0]   o_entry_index;
    logic [PAGES_W-1:0] o_granted_pages;
    logic [PAGES_W-1:0] o_free_after;
    logic               o_last;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]  pwdata = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    page_count_table_allocator uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_cmd           (i_cmd),
        .i_request_pages (i_request_pages),
        .i_release_entry (i_release_entry),
        .o_result_valid  (o_result_valid),
        .o_status        (o_status),
        .o_entry_index   (o_entry_index),
        .o_granted_pages (o_granted_pages),
        .o_free_after    (o_free_after),
        .o_last          (o_last),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 0;
    end

    // ------------------------------------------------------------------
    // predictor state: raw registers plus the table they load
    // ------------------------------------------------------------------
    logic [CNT_W-1:0]   reg_count = DEF_ENTRY_COUNT;
    logic [MAXP_W-1:0]  reg_max   = DEF_MAX_PAGES;
    logic [PAGES_W-1:0] reg_total = DEF_TOTAL_PAGES;

    int              slots_used;     // entry count after clamping
    longint unsigned slot_cap;       // per-entry maximum after clamping
    longint unsigned pool_cap;       // clamped total
    longint unsigned pool_free;      // total free pages
    longint unsigned slot_free [16];

    t_grant    pending_grants [$];   // results still owed by the block
    t_plan_row directed_plan [$];
    int        mismatch_count = 0;
    bit        gaps_on = 1'b1;

    // append one owed result at the tail
    function automatic void owe_grant(t_grant g);
        pending_grants.insert(pending_grants.size(), g);
    endfunction

    // append one line to the directed plan
    function automatic void add_row(t_plan_row r);
        directed_plan.insert(directed_plan.size(), r);
    endfunction

    // reload the table the way a reset or register write does
    function automatic void load_slots();
        longint unsigned remain;
        slots_used = (reg_count == 0) ? 1 : int'(reg_count);
        if (slots_used > SLOT_LIMIT) slots_used = SLOT_LIMIT;
        slot_cap = (reg_max == 0) ? 1 : reg_max;
        if (slot_cap > PER_MAX) slot_cap = PER_MAX;
        pool_cap = reg_total;
        if (pool_cap > slot_cap * slots_used) pool_cap = slot_cap * slots_used;
        if (pool_cap > PAGE_CEIL) pool_cap = PAGE_CEIL;
        // fill entries in index order, each up to the per-entry maximum
        remain = pool_cap;
        for (int i = 0; i < 16; i++) begin
            slot_free[i] = 0;
            if (i < slots_used) begin
                slot_free[i] = (remain < slot_cap) ? remain : slot_cap;
                remain -= slot_free[i];
            end
        end
        pool_free = pool_cap;
    endfunction

    function automatic t_grant make_grant(logic [1:0] st, int idx, longint unsigned pages);
        t_grant g;
        g = '0;
        g.status = st;
        g.slot = IDX_W'(idx);
        g.granted = PAGES_W'(pages);
        return g;
    endfunction

    // work out the results of one accepted request and queue them
    function automatic void predict_request(logic cmd, logic [PAGES_W-1:0] pages,
                                            logic [IDX_W-1:0] ent);
        longint unsigned want;
        longint unsigned take;
        int              first_fit;
        t_grant          batch [$];
        want = pages;
        first_fit = -1;
        if (cmd == CMD_RELEASE) begin
            // bad entry, pool overflow or entry overflow leave state alone
            if (ent >= slots_used || pool_free + want > pool_cap ||
                slot_free[ent] + want > slot_cap) begin
                batch.insert(batch.size(), make_grant(STAT_BADREL, ent, 0));
            end else begin
                slot_free[ent] += want;
                pool_free += want;
                batch.insert(batch.size(), make_grant(STAT_OK, ent, want));
            end
        end else if (want == 0) begin
            batch.insert(batch.size(), make_grant(STAT_OK, 0, 0));
        end else if (want > pool_free) begin
            batch.insert(batch.size(), make_grant(STAT_NOFREE, 0, 0));
        end else begin
            for (int i = 0; i < slots_used && first_fit < 0; i++)
                if (slot_free[i] >= want) first_fit = i;
            pool_free -= want;
            if (first_fit >= 0) begin
                slot_free[first_fit] -= want;
                batch.insert(batch.size(), make_grant(STAT_OK, first_fit, want));
            end else begin
                // spill over the entries in index order
                for (int i = 0; i < slots_used && want > 0; i++) begin
                    if (slot_free[i] > 0) begin
                        take = (slot_free[i] < want) ? slot_free[i] : want;
                        slot_free[i] -= take;
                        want -= take;
                        batch.insert(batch.size(), make_grant(STAT_OK, i, take));
                    end
                end
            end
            if (batch.size() == 0) batch.insert(0, make_grant(STAT_OK, 0, 0));
        end
        foreach (batch[k]) begin
            batch[k].free_after = PAGES_W'(pool_free);
            batch[k].last = (k == batch.size() - 1);
            owe_grant(batch[k]);
        end
    endfunction

    // ------------------------------------------------------------------
    // result checking against the oldest expectation
    // ------------------------------------------------------------------
    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin : result_check
        t_grant want_g;
        if (i_rst_n && o_result_valid) begin
            if (pending_grants.size() == 0) begin
                $error("unexpected result: status %0d entry %0d granted %0d",
                       o_status, o_entry_index, o_granted_pages);
                mismatch_count++;
            end else begin
                want_g = pending_grants.pop_front();
                check_field("status", want_g.status, o_status);
                check_field("entry_index", want_g.slot, o_entry_index);
                check_field("granted_pages", want_g.granted, o_granted_pages);
                check_field("free_after", want_g.free_after, o_free_after);
                check_field("last", want_g.last, o_last);
            end
        end
    end

    // ------------------------------------------------------------------
    // drivers: inputs move on the falling edge, handshakes seen on rising
    // ------------------------------------------------------------------

    // present one request and hold it until the block takes it
    task automatic issue_request(logic cmd, logic [PAGES_W-1:0] pages,
                                 logic [IDX_W-1:0] ent);
        @(negedge i_clk);
        start <= 1'b1;
        i_cmd <= cmd;
        i_request_pages <= pages;
        i_release_entry <= ent;
        do @(posedge i_clk); while (busy);
        predict_request(cmd, pages, ent);
    endtask

    // idle the request side, with junk on the fields
    task automatic hold_off(int unsigned cycles);
        if (cycles != 0) begin
            @(negedge i_clk);
            start <= 1'b0;
            i_cmd <= 1'($urandom());
            i_request_pages <= PAGES_W'($urandom());
            i_release_entry <= IDX_W'($urandom());
            repeat (cycles - 1) @(negedge i_clk);
        end
    endtask

    // stop sending and let every owed result come back
    task automatic wait_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_grants.size() != 0) @(posedge i_clk);
    endtask

    // apb write: setup then access, only while the block is idle
    task automatic write_register(logic [1:0] idx, logic [DATA_W-1:0] value);
        do @(posedge i_clk); while (busy);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_ENTRY_COUNT: reg_count = value[CNT_W-1:0];
            REG_MAX_PAGES:   reg_max = value[MAXP_W-1:0];
            REG_TOTAL_PAGES: reg_total = value[PAGES_W-1:0];
            default: ;
        endcase
        load_slots();
    endtask

    // mostly no gap, some short, a few long
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (!gaps_on || roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // random request shaped by the current table
    task automatic random_request();
        int unsigned        roll;
        logic               cmd;
        logic [PAGES_W-1:0] pages;
        logic [IDX_W-1:0]   ent;
        longint unsigned    room;
        roll = $urandom_range(0, 99);
        ent = IDX_W'($urandom_range(0, 15));
        cmd = CMD_ALLOC;
        if (roll < 4) begin
            pages = '0;
        end else if (roll < 9) begin
            // full-width noise, almost always beyond the free count
            pages = PAGES_W'($urandom());
        end else if (roll < 14) begin
            pages = PAGES_W'(pool_free + $urandom_range(1, 8));
        end else if (roll < 40) begin
            // sized to fit one entry, first-fit path
            pages = PAGES_W'($urandom_range(1, slot_cap));
        end else if (roll < 60) begin
            // anything up to the free count, often spills
            pages = (pool_free == 0) ? PAGES_W'(1) : PAGES_W'($urandom_range(1, pool_free));
        end else begin
            cmd = CMD_RELEASE;
            if (roll < 68) begin
                // any entry, any amount: many of these are rejected
                pages = PAGES_W'($urandom_range(0, 2 * slot_cap));
            end else begin
                ent = IDX_W'($urandom_range(0, slots_used - 1));
                room = slot_cap - slot_free[ent];
                if (pool_cap - pool_free < room) room = pool_cap - pool_free;
                pages = PAGES_W'($urandom_range(0, room));
            end
        end
        issue_request(cmd, pages, ent);
    endtask

    // new random configuration, registers written in a rotated order
    task automatic random_setup();
        int unsigned       roll;
        int unsigned       cnt;
        int unsigned       mx;
        int unsigned       first;
        logic [1:0]        idx;
        logic [DATA_W-1:0] setting [3];
        roll = $urandom_range(0, 99);
        if (roll < 10) cnt = 0;
        else if (roll < 20) cnt = $urandom_range(17, 31);
        else cnt = $urandom_range(1, 16);
        roll = $urandom_range(0, 99);
        if (roll < 70) mx = $urandom_range(1, 64);
        else if (roll < 90) mx = $urandom_range(65, 5000);
        else mx = $urandom() & 32'h1FFFFF;
        setting[REG_ENTRY_COUNT] = cnt;
        setting[REG_MAX_PAGES] = mx;
        // clamp locally so the total mostly lands inside capacity
        if (cnt == 0) cnt = 1;
        if (cnt > 16) cnt = 16;
        if (mx == 0) mx = 1;
        if (mx > PER_MAX) mx = PER_MAX;
        if ($urandom_range(0, 99) < 15) setting[REG_TOTAL_PAGES] = $urandom() & 32'h1FFFFFF;
        else setting[REG_TOTAL_PAGES] = $urandom_range(0, cnt * mx);
        first = $urandom_range(0, 2);
        for (int k = 0; k < 3; k++) begin
            idx = 2'((first + k) % 3);
            write_register(idx, setting[idx]);
        end
    endtask

    // ------------------------------------------------------------------
    // directed plan helpers
    // ------------------------------------------------------------------
    function automatic t_plan_row req_row(logic cmd, logic [PAGES_W-1:0] pages,
                                          logic [IDX_W-1:0] slot);
        t_plan_row r;
        r.is_write = 1'b0;
        r.reg_idx = '0;
        r.reg_value = '0;
        r.cmd = cmd;
        r.pages = pages;
        r.slot = slot;
        r.typed = 1'b0;
        r.want = '0;
        return r;
    endfunction

    // request whose single result is known by inspection
    function automatic t_plan_row checked_row(logic cmd, logic [PAGES_W-1:0] pages,
                                              logic [IDX_W-1:0] slot, logic [1:0] st,
                                              logic [IDX_W-1:0] idx,
                                              logic [PAGES_W-1:0] granted,
                                              logic [PAGES_W-1:0] free_after);
        t_plan_row r;
        r = req_row(cmd, pages, slot);
        r.typed = 1'b1;
        r.want = '{status: st, slot: idx, granted: granted, free_after: free_after,
                   last: 1'b1};
        return r;
    endfunction

    function automatic t_plan_row write_row(logic [1:0] idx, logic [DATA_W-1:0] value);
        t_plan_row r;
        r = req_row(CMD_ALLOC, '0, '0);
        r.is_write = 1'b1;
        r.reg_idx = idx;
        r.reg_value = value;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        t_plan_row row;

        load_slots();

        // defaults: sixteen entries of 4096, all free
        add_row(checked_row(CMD_ALLOC, 0, 15, STAT_OK, 0, 0, 65536));
        add_row(checked_row(CMD_ALLOC, 65537, 0, STAT_NOFREE, 0, 0, 65536));
        add_row(checked_row(CMD_ALLOC, 25'h1FFFFFF, 0, STAT_NOFREE, 0, 0, 65536));
        // release into a full pool is rejected
        add_row(checked_row(CMD_RELEASE, 1, 0, STAT_BADREL, 0, 0, 65536));
        add_row(checked_row(CMD_ALLOC, 1, 0, STAT_OK, 0, 1, 65535));
        // entry 0 now one short, first fit moves to entry 1
        add_row(checked_row(CMD_ALLOC, 4096, 0, STAT_OK, 1, 4096, 61439));
        // no single entry holds it: spill over entries 0 and 2
        add_row(req_row(CMD_ALLOC, 5000, 0));
        // entry 15 is already at its maximum
        add_row(checked_row(CMD_RELEASE, 1, 15, STAT_BADREL, 15, 0, 56439));
        add_row(req_row(CMD_RELEASE, 4095, 0));
        add_row(req_row(CMD_ALLOC, 60534, 0));
        add_row(req_row(CMD_RELEASE, 4096, 3));

        // every register at its top: all clamps engage
        add_row(write_row(REG_ENTRY_COUNT, 32'hFFFFFFFF));
        add_row(write_row(REG_MAX_PAGES, 32'hFFFFFFFF));
        add_row(write_row(REG_TOTAL_PAGES, 32'hFFFFFFFF));
        // whole pool in one request: one result per entry
        add_row(req_row(CMD_ALLOC, 25'h1000000, 0));
        add_row(req_row(CMD_RELEASE, 25'h100000, 5));
        add_row(checked_row(CMD_ALLOC, 25'h100001, 0, STAT_NOFREE, 0, 0, 25'h100000));
        add_row(req_row(CMD_RELEASE, 1, 15));

        // every register zero: one entry of one page, nothing free
        add_row(write_row(REG_ENTRY_COUNT, 32'h0));
        add_row(write_row(REG_MAX_PAGES, 32'h0));
        add_row(write_row(REG_TOTAL_PAGES, 32'h0));
        add_row(checked_row(CMD_ALLOC, 1, 0, STAT_NOFREE, 0, 0, 0));
        add_row(checked_row(CMD_RELEASE, 0, 0, STAT_OK, 0, 0, 0));
        // entry beyond the count in use
        add_row(checked_row(CMD_RELEASE, 0, 1, STAT_BADREL, 1, 0, 0));
        add_row(checked_row(CMD_ALLOC, 0, 9, STAT_OK, 0, 0, 0));

        // smallest useful table: a single page
        add_row(write_row(REG_TOTAL_PAGES, 32'h1));
        add_row(checked_row(CMD_ALLOC, 1, 0, STAT_OK, 0, 1, 0));
        add_row(checked_row(CMD_RELEASE, 2, 0, STAT_BADREL, 0, 0, 0));
        add_row(checked_row(CMD_RELEASE, 1, 0, STAT_OK, 0, 1, 1));

        // synchronous reset, then the block reloads on its own
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_plan[n]) begin
            row = directed_plan[n];
            if (row.is_write) begin
                wait_results();
                write_register(row.reg_idx, row.reg_value);
            end else begin
                issue_request(row.cmd, row.pages, row.slot);
                // known answer replaces the predicted one
                if (row.typed) begin
                    pending_grants[pending_grants.size() - 1] = row.want;
                end
                hold_off(pick_gap());
            end
        end

        // random phases, each with its own configuration; one runs back to back
        for (int phase = 0; phase < 6; phase++) begin
            wait_results();
            random_setup();
            gaps_on = (phase != 2);
            repeat (31) begin
                random_request();
                // now and then stop until the block has caught up
                if ($urandom_range(0, 99) < 3) wait_results();
                else hold_off(pick_gap());
            end
        end

        wait_results();
        repeat (40) @(posedge i_clk);
        if (mismatch_count == 0 && pending_grants.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // hang guard, far beyond the slowest correct run
    initial begin : watchdog
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
